/* hdl/cte_pkg.sv */
// Shared types, constants and helper functions for the cue track span extractor.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package cte_pkg;

  localparam int unsigned TRACK_W    = 7;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned FRAMES_W   = 19;
  localparam int unsigned OFFSET_W   = 30;
  localparam int unsigned BPF_W      = 12;
  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [TRACK_W-1:0] TRACK_RESET     = 7'd1;
  localparam logic [TRACK_W-1:0] TRACK_MAX       = 7'd99;
  localparam logic [BPF_W-1:0]   BYTES_PER_FRAME = 12'd2352;

  localparam logic [POS_W-1:0] LEN_FULL  = 4'd8;
  localparam logic [POS_W-1:0] LEN_INDEX = 4'd5;
  localparam logic [POS_W-1:0] SKIP_LAST = 4'd3;

  localparam logic [2:0] TPOS_SEP0 = 3'd2;
  localparam logic [2:0] TPOS_SEP1 = 3'd5;
  localparam logic [2:0] TPOS_LAST = 3'd7;

  localparam logic [0:0] REG_TRACK = 1'b0;

  typedef enum logic [2:0] {
    PH_TRACK      = 3'd0,
    PH_INDEX01    = 3'd1,
    PH_SKIP_ONE   = 3'd2,
    PH_START_TIME = 3'd3,
    PH_INDEX      = 3'd4,
    PH_SKIP_FOUR  = 3'd5,
    PH_END_TIME   = 3'd6,
    PH_DONE       = 3'd7
  } phase_t;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] ones;
    logic       track_ok;
  } track_cfg_t;

  typedef struct packed {
    logic [FRAMES_W-1:0] start_frames;
    logic                start_found;
    logic [FRAMES_W-1:0] end_frames;
    logic                end_found;
  } span_t;

  function automatic logic [BYTE_W-1:0] index_char(input logic [2:0] pos);
    logic [BYTE_W-1:0] c;
    case (pos)
      3'd0:    c = "I";
      3'd1:    c = "N";
      3'd2:    c = "D";
      3'd3:    c = "E";
      3'd4:    c = "X";
      3'd5:    c = " ";
      3'd6:    c = "0";
      default: c = "1";
    endcase
    return c;
  endfunction

  function automatic logic [BYTE_W-1:0] track_char(input logic [2:0] pos,
                                                   input logic [3:0] tens,
                                                   input logic [3:0] ones);
    logic [BYTE_W-1:0] c;
    case (pos)
      3'd0:    c = "T";
      3'd1:    c = "R";
      3'd2:    c = "A";
      3'd3:    c = "C";
      3'd4:    c = "K";
      3'd5:    c = " ";
      3'd6:    c = {4'h3, tens};
      default: c = {4'h3, ones};
    endcase
    return c;
  endfunction

  function automatic logic [15:0] digit_weight(input logic [2:0] pos);
    logic [15:0] w;
    case (pos)
      3'd0:    w = 16'd45000;
      3'd1:    w = 16'd4500;
      3'd3:    w = 16'd750;
      3'd4:    w = 16'd75;
      3'd6:    w = 16'd10;
      3'd7:    w = 16'd1;
      default: w = 16'd0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* hdl/cte_cfg.sv */
// APB-style register file holding the wanted track number and its decimal digits.
// Depends on cte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cte_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [cte_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [cte_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic      [cte_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                   cfg_pready,
  output cte_pkg::track_cfg_t                    track_cfg
);

  logic [cte_pkg::TRACK_W-1:0] track_r, track_nxt;
  cte_pkg::track_cfg_t         digits_r, digits_nxt;
  logic                        wr_en;
  logic [cte_pkg::TRACK_W-1:0] wdata;
  logic [3:0]                  tens;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite &&
                 (cfg_paddr[2] == cte_pkg::REG_TRACK);
  assign wdata = cfg_pwdata[cte_pkg::TRACK_W-1:0];

  always_comb begin
    tens = 4'd0;
    for (int q = 1; q < 10; q++) begin
      if (wdata >= cte_pkg::TRACK_W'(q * 10)) begin
        tens = 4'(q);
      end
    end
    track_nxt = track_r;
    digits_nxt = digits_r;
    if (wr_en) begin
      track_nxt = wdata;
      digits_nxt.tens = tens;
      digits_nxt.ones = 4'(wdata - ({3'd0, tens} * 7'd10));
      digits_nxt.track_ok = (wdata <= cte_pkg::TRACK_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_r <= cte_pkg::TRACK_RESET;
      digits_r.tens <= 4'd0;
      digits_r.ones <= 4'd1;
      digits_r.track_ok <= 1'b1;
    end else begin
      track_r <= track_nxt;
      digits_r <= digits_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == cte_pkg::REG_TRACK) begin
      cfg_prdata = {{(cte_pkg::CFG_DATA_W - cte_pkg::TRACK_W){1'b0}}, track_r};
    end
  end

  assign track_cfg = digits_r;

endmodule

`default_nettype wire

/* hdl/cte_scan.sv */
// Byte scanner: pattern searches, time parsing and frame accumulation per item.
// Depends on cte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cte_scan (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire cte_pkg::track_cfg_t           track_cfg,
  input  wire logic                          in_accept,
  input  wire logic [cte_pkg::BYTE_W-1:0]    in_byte,
  input  wire logic                          in_last,
  output logic                               span_valid,
  output cte_pkg::span_t                     span
);

  cte_pkg::phase_t                phase_r, phase_nxt;
  logic [cte_pkg::POS_W-1:0]      pos_r, pos_nxt;
  logic [cte_pkg::FRAMES_W-1:0]   acc_r, acc_nxt;
  logic                           good_r, good_nxt;
  cte_pkg::span_t                 span_r, span_nxt;

  logic [cte_pkg::POS_W-1:0]      pat_len;
  logic [cte_pkg::BYTE_W-1:0]     pat_chr;
  logic [cte_pkg::BYTE_W-1:0]     first_chr;
  logic [cte_pkg::POS_W-1:0]      search_pos;
  logic                           search_hit;
  logic [2:0]                     tpos;
  logic                           is_digit;
  logic                           tskip;
  logic [cte_pkg::FRAMES_W-1:0]   acc_add;
  logic                           good_t;

  always_comb begin
    pat_len = (phase_r == cte_pkg::PH_INDEX) ? cte_pkg::LEN_INDEX : cte_pkg::LEN_FULL;
    if (phase_r == cte_pkg::PH_TRACK) begin
      pat_chr = cte_pkg::track_char(pos_r[2:0], track_cfg.tens, track_cfg.ones);
      first_chr = "T";
    end else begin
      pat_chr = cte_pkg::index_char(pos_r[2:0]);
      first_chr = "I";
    end
    if ((pos_r < pat_len) && (in_byte == pat_chr)) begin
      search_pos = pos_r + 4'd1;
    end else begin
      search_pos = (in_byte == first_chr) ? 4'd1 : 4'd0;
    end
    search_hit = (search_pos >= pat_len);

    tpos = pos_r[2:0];
    is_digit = (in_byte >= "0") && (in_byte <= "9");
    tskip = (tpos == cte_pkg::TPOS_SEP0) || (tpos == cte_pkg::TPOS_SEP1);
    acc_add = acc_r + ({15'd0, in_byte[3:0]} * {3'd0, cte_pkg::digit_weight(tpos)});
    good_t = good_r;
    if (!tskip && !is_digit) begin
      good_t = 1'b0;
    end

    phase_nxt = phase_r;
    pos_nxt = pos_r;
    acc_nxt = acc_r;
    good_nxt = good_r;
    span_nxt = span_r;

    unique case (phase_r)
      cte_pkg::PH_TRACK: begin
        if (track_cfg.track_ok) begin
          pos_nxt = search_hit ? 4'd0 : search_pos;
          if (search_hit) phase_nxt = cte_pkg::PH_INDEX01;
        end else begin
          pos_nxt = 4'd0;
        end
      end
      cte_pkg::PH_INDEX01: begin
        pos_nxt = search_hit ? 4'd0 : search_pos;
        if (search_hit) phase_nxt = cte_pkg::PH_SKIP_ONE;
      end
      cte_pkg::PH_SKIP_ONE: begin
        phase_nxt = cte_pkg::PH_START_TIME;
        pos_nxt = 4'd0;
        acc_nxt = '0;
        good_nxt = 1'b1;
      end
      cte_pkg::PH_START_TIME, cte_pkg::PH_END_TIME: begin
        good_nxt = good_t;
        if (!tskip && is_digit) acc_nxt = acc_add;
        if (tpos == cte_pkg::TPOS_LAST) begin
          pos_nxt = 4'd0;
          if (phase_r == cte_pkg::PH_START_TIME) begin
            phase_nxt = cte_pkg::PH_INDEX;
            if (good_t) begin
              span_nxt.start_frames = acc_nxt;
              span_nxt.start_found = 1'b1;
            end
          end else begin
            phase_nxt = cte_pkg::PH_DONE;
            if (good_t) begin
              span_nxt.end_frames = acc_nxt;
              span_nxt.end_found = 1'b1;
            end
          end
        end else begin
          pos_nxt = {1'b0, tpos} + 4'd1;
        end
      end
      cte_pkg::PH_INDEX: begin
        pos_nxt = search_hit ? 4'd0 : search_pos;
        if (search_hit) phase_nxt = cte_pkg::PH_SKIP_FOUR;
      end
      cte_pkg::PH_SKIP_FOUR: begin
        if (pos_r >= cte_pkg::SKIP_LAST) begin
          phase_nxt = cte_pkg::PH_END_TIME;
          pos_nxt = 4'd0;
          acc_nxt = '0;
          good_nxt = 1'b1;
        end else begin
          pos_nxt = pos_r + 4'd1;
        end
      end
      cte_pkg::PH_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_accept && in_last)) begin
      phase_r <= cte_pkg::PH_TRACK;
      pos_r <= '0;
      acc_r <= '0;
      good_r <= 1'b1;
      span_r <= '0;
    end else if (in_accept) begin
      phase_r <= phase_nxt;
      pos_r <= pos_nxt;
      acc_r <= acc_nxt;
      good_r <= good_nxt;
      span_r <= span_nxt;
    end
  end

  assign span_valid = in_accept && in_last;
  assign span = span_nxt;

endmodule

`default_nettype wire

/* hdl/cte_out.sv */
// Result path: span holding stage, offset multiply and output register with handshake.
// Depends on cte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cte_out (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               span_valid,
  input  wire cte_pkg::span_t                     span,
  output logic                                    take_ok,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic      [cte_pkg::OUT_DATA_W-1:0]     out_tdata
);

  cte_pkg::span_t                  hold_r;
  logic                            hold_valid_r, hold_valid_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [cte_pkg::OUT_DATA_W-1:0]  data_r;
  logic                            out_load;
  logic                            hold_move;
  logic [cte_pkg::OFFSET_W-1:0]    start_off;
  logic [cte_pkg::OFFSET_W-1:0]    end_off;

  assign out_load = !out_valid_r || out_tready;
  assign hold_move = hold_valid_r && out_load;
  assign take_ok = !hold_valid_r || hold_move;

  assign start_off = {11'd0, hold_r.start_frames} * {18'd0, cte_pkg::BYTES_PER_FRAME};
  assign end_off = {11'd0, hold_r.end_frames} * {18'd0, cte_pkg::BYTES_PER_FRAME};

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (span_valid) begin
      hold_valid_nxt = 1'b1;
    end else if (hold_move) begin
      hold_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (hold_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (span_valid) begin
      hold_r <= span;
    end
    if (hold_move) begin
      data_r <= {2'b00, hold_r.end_found, end_off, hold_r.start_found, start_off};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = data_r;

endmodule

`default_nettype wire

/* hdl/cue_track_span_extractor.sv */
// Cue-sheet track span extractor: one byte item per cycle, one result per sheet.
// Result: last byte's span enters the hold stage, then the output register.
// Throughput: 1 byte item per cycle; in_tready drops only while both the span
// hold stage and the output register are full and out_tready is low.
// Reset: synchronous active-low rst_n clears scan state and results; track = 1.
// Depends on cte_pkg, cte_cfg, cte_scan and cte_out.
`timescale 1ns / 1ps
`default_nettype none

module cue_track_span_extractor (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [7:0]                         in_tdata,   // [7:0] byte_value
  input  wire logic                               in_tlast,   // last_byte
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [29:0] start_offset, [30] start_valid, [60:31] end_offset, [61] end_valid
  output logic      [cte_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [cte_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [cte_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic      [cte_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                    cfg_pready
);

  cte_pkg::track_cfg_t track_cfg;
  cte_pkg::span_t      span;
  logic                span_valid;
  logic                take_ok;
  logic                in_accept;

  assign in_tready = take_ok;
  assign in_accept = in_tvalid && take_ok;

  cte_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .track_cfg   (track_cfg)
  );

  cte_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .track_cfg  (track_cfg),
    .in_accept  (in_accept),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .span_valid (span_valid),
    .span       (span)
  );

  cte_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .span_valid (span_valid),
    .span       (span),
    .take_ok    (take_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

/* tb/tb_cue_track_span_extractor.sv */
// Self-checking testbench for cue_track_span_extractor: feeds cue-sheet byte items,
// predicts the track start/end byte offsets of each sheet and checks every result.
// Depends on cte_pkg and the cue_track_span_extractor RTL.
`timescale 1ns / 1ps

module tb_cue_track_span_extractor;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam logic [cte_pkg::CFG_ADDR_W-1:0] TRACK_ADDR =
    cte_pkg::CFG_ADDR_W'(4 * cte_pkg::REG_TRACK);
  localparam bit [63:0] INDEX_PAT = "10 XEDNI";  // "INDEX 01", first char in low byte

  typedef struct packed {
    bit [cte_pkg::OFFSET_W-1:0] start_off;
    bit                         start_ok;
    bit [cte_pkg::OFFSET_W-1:0] end_off;
    bit                         end_ok;
  } span_rec_t;

  class span_scoreboard;
    bit [cte_pkg::TRACK_W-1:0]  track_sel;
    cte_pkg::phase_t            scan_ph;
    bit [cte_pkg::POS_W-1:0]    mpos;
    bit [cte_pkg::FRAMES_W-1:0] facc;
    bit                         dgood;
    bit [cte_pkg::FRAMES_W-1:0] st_frames;
    bit                         st_found;
    bit [cte_pkg::FRAMES_W-1:0] en_frames;
    bit                         en_found;
    span_rec_t                  expected_spans[$];
    int                         errors;
    int                         n_bytes;
    int                         n_due;
    int                         n_checked;

    function new();
      track_sel = cte_pkg::TRACK_RESET;
      clear_scan();
    endfunction

    function void clear_scan();
      scan_ph   = cte_pkg::PH_TRACK;
      mpos      = '0;
      facc      = '0;
      dgood     = 1'b1;
      st_frames = '0;
      st_found  = 1'b0;
      en_frames = '0;
      en_found  = 1'b0;
    endfunction

    function bit advance_match(bit [63:0] pat, int len, bit [7:0] b);
      int pos;
      pos = mpos;
      if (pos < len && b == pat[8*pos +: 8]) pos++;
      else pos = (b == pat[7:0]) ? 1 : 0;
      if (pos >= len) begin
        mpos = '0;
        return 1'b1;
      end
      mpos = cte_pkg::POS_W'(pos);
      return 1'b0;
    endfunction

    function void begin_time(cte_pkg::phase_t nxt);
      scan_ph = nxt;
      mpos    = '0;
      facc    = '0;
      dgood   = 1'b1;
    endfunction

    // mm:ss:ff, separators at positions 2 and 5 are not looked at
    function bit take_time_byte(bit [7:0] b);
      int pos;
      int unit;
      pos = mpos & 7;
      if (pos != 2 && pos != 5) begin
        unit = (pos < 2) ? 4500 : ((pos < 5) ? 75 : 1);
        if (pos % 3 == 0) unit = unit * 10;
        if (b >= "0" && b <= "9")
          facc = cte_pkg::FRAMES_W'(int'(facc) + int'(b - "0") * unit);
        else dgood = 1'b0;
      end
      if (pos == 7) begin
        mpos = '0;
        return 1'b1;
      end
      mpos = cte_pkg::POS_W'(pos + 1);
      return 1'b0;
    endfunction

    function void note_byte(bit [7:0] b, bit last);
      bit [63:0] tpat;
      span_rec_t r;
      n_bytes++;
      case (scan_ph)
        cte_pkg::PH_TRACK: begin
          if (track_sel <= cte_pkg::TRACK_MAX) begin
            tpat = {8'(8'h30 + track_sel % 10), 8'(8'h30 + track_sel / 10), " KCART"};
            if (advance_match(tpat, 8, b)) scan_ph = cte_pkg::PH_INDEX01;
          end else begin
            mpos = '0;
          end
        end
        cte_pkg::PH_INDEX01: begin
          if (advance_match(INDEX_PAT, 8, b)) scan_ph = cte_pkg::PH_SKIP_ONE;
        end
        cte_pkg::PH_SKIP_ONE: begin_time(cte_pkg::PH_START_TIME);
        cte_pkg::PH_START_TIME: begin
          if (take_time_byte(b)) begin
            if (dgood) begin
              st_frames = facc;
              st_found  = 1'b1;
            end
            scan_ph = cte_pkg::PH_INDEX;
          end
        end
        cte_pkg::PH_INDEX: begin
          if (advance_match(INDEX_PAT, 5, b)) scan_ph = cte_pkg::PH_SKIP_FOUR;
        end
        cte_pkg::PH_SKIP_FOUR: begin
          if (mpos >= 3) begin_time(cte_pkg::PH_END_TIME);
          else mpos = mpos + 1'b1;
        end
        cte_pkg::PH_END_TIME: begin
          if (take_time_byte(b)) begin
            if (dgood) begin
              en_frames = facc;
              en_found  = 1'b1;
            end
            scan_ph = cte_pkg::PH_DONE;
          end
        end
        default: ;
      endcase
      if (last) begin
        r.start_off = st_found ? cte_pkg::OFFSET_W'(longint'(st_frames) * 2352) : '0;
        r.start_ok  = st_found;
        r.end_off   = en_found ? cte_pkg::OFFSET_W'(longint'(en_frames) * 2352) : '0;
        r.end_ok    = en_found;
        expected_spans.push_back(r);
        n_due++;
        clear_scan();
      end
    endfunction

    function void report(string name, longint exp_v, logic [63:0] act_v);
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      errors++;
    endfunction

    function void check_span(logic [63:0] d);
      span_rec_t e;
      if (expected_spans.size() == 0) begin
        $display("%0t: unexpected span result, expected none, got %h", $time, d);
        errors++;
        return;
      end
      e = expected_spans.pop_front();
      n_checked++;
      if (d[29:0] !== e.start_off) report("start_offset", e.start_off, d[29:0]);
      if (d[30] !== e.start_ok) report("start_valid", e.start_ok, d[30]);
      if (d[60:31] !== e.end_off) report("end_offset", e.end_off, d[60:31]);
      if (d[61] !== e.end_ok) report("end_valid", e.end_ok, d[61]);
      if (d[63:62] !== 2'b00) report("tdata pad", 0, d[63:62]);
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [7:0]                     in_tdata;   // [7:0] byte_value
  logic                           in_tlast;   // last_byte
  logic                           out_tvalid;
  logic                           out_tready;
  // [29:0] start_offset, [30] start_valid, [60:31] end_offset, [61] end_valid
  logic [cte_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           cfg_psel;
  logic                           cfg_penable;
  logic                           cfg_pwrite;
  logic [cte_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [cte_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [cte_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                           cfg_pready;

  span_scoreboard sb;
  bit [7:0]       sheet_q[$];
  bit             no_idle;
  bit             hold_req;
  int             idle_run;

  cue_track_span_extractor DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
      if (idle_run >= STALL_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("cue_track_span_extractor verification failed");
        $finish;
      end
    end
  end

  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = no_idle ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      sb.check_span(out_tdata);
    end
  end

  task automatic push_byte(input bit [7:0] b, input bit last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_byte(b, last);
    @(negedge clk);
  endtask

  task automatic send_sheet();
    no_idle = ($urandom_range(0, 4) == 0);
    foreach (sheet_q[i]) push_byte(sheet_q[i], i == sheet_q.size() - 1);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.expected_spans.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_track(input bit [cte_pkg::TRACK_W-1:0] tn);
    bit [cte_pkg::CFG_DATA_W-1:0] wdata;
    wdata = {($urandom_range(0, 1) != 0) ? 25'($urandom) : 25'd0, tn};
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= TRACK_ADDR;
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.track_sel = tn;
    @(negedge clk);
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== {25'd0, tn}) begin
      $display("%0t: track readback mismatch, expected %0d, got %0d", $time, tn, cfg_prdata);
      sb.errors++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic void add_str(input string s);
    for (int i = 0; i < s.len(); i++) sheet_q.push_back(s[i]);
  endfunction

  function automatic void add_noise(input int n);
    string pool;
    pool = "TRACKINDEX 0129:";
    repeat (n) begin
      if ($urandom_range(0, 2) == 0) sheet_q.push_back(pool[$urandom_range(0, pool.len() - 1)]);
      else sheet_q.push_back(8'($urandom));
    end
  endfunction

  function automatic void add_time();
    bit [7:0] tm[8];
    bit [7:0] v;
    int       digit_pos[6];
    bit       all_nines;
    digit_pos = '{0, 1, 3, 4, 6, 7};
    all_nines = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < 8; i++) tm[i] = all_nines ? "9" : 8'(8'h30 + $urandom_range(0, 9));
    tm[2] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : ":";
    tm[5] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : ":";
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 2))
        0:       v = "/";
        1:       v = ":";
        default: v = 8'($urandom);
      endcase
      if (v >= "0" && v <= "9") v = v ^ 8'h40;
      tm[digit_pos[$urandom_range(0, 5)]] = v;
    end
    for (int i = 0; i < 8; i++) sheet_q.push_back(tm[i]);
  endfunction

  function automatic void build_sheet(input int tn);
    int t;
    int cut;
    sheet_q.delete();
    add_noise($urandom_range(0, 3));
    if ($urandom_range(0, 9) != 0) begin
      t = ($urandom_range(0, 4) != 0) ? tn : $urandom_range(0, 99);
      add_str($sformatf("TRACK %02d", t));
      add_noise($urandom_range(0, 3));
      add_str("INDEX 01");
      sheet_q.push_back(8'($urandom));
      add_time();
      add_noise($urandom_range(0, 3));
      add_str("INDEX");
      repeat (4) sheet_q.push_back(8'($urandom));
      add_time();
      add_noise($urandom_range(0, 3));
    end else begin
      add_noise($urandom_range(1, 20));
    end
    if (sheet_q.size() > 1 && $urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, sheet_q.size() - 1);
      while (sheet_q.size() > cut) void'(sheet_q.pop_back());
    end
  endfunction

  initial begin
    int trk_plan[9];
    int phase_base;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    no_idle     = 1'b0;
    hold_req    = 1'b0;
    sb = new();
    trk_plan = '{0, 99, 100, 127, $urandom_range(0, 99), $urandom_range(0, 99),
                 $urandom_range(0, 99), 1, $urandom_range(0, 99)};
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // full sheet at reset track: largest start time, zero end time
    sheet_q.delete();
    add_str("TRACK 01INDEX 01 99:99:99INDEX 00 00:00:00");
    send_sheet();
    // a lone zero byte
    sheet_q.delete();
    sheet_q.push_back(8'h00);
    send_sheet();
    // bad start digit, then the sheet ends inside the end search
    sheet_q.delete();
    add_str("TRACK 01INDEX 01 0a:00:00IND");
    send_sheet();

    foreach (trk_plan[p]) begin
      settle();
      write_track(cte_pkg::TRACK_W'(trk_plan[p]));
      if (p == 2) begin
        hold_req = 1'b1;
        repeat (16) begin
          sheet_q.delete();
          add_noise($urandom_range(1, 3));
          send_sheet();
        end
      end
      phase_base = sb.n_bytes;
      while (sb.n_bytes - phase_base < 150) begin
        build_sheet(trk_plan[p]);
        send_sheet();
      end
    end
    while (sb.n_bytes < 1600 || sb.n_due < 48) begin
      build_sheet(trk_plan[8]);
      send_sheet();
    end
    settle();
    repeat (8) @(negedge clk);

    $display("Sent %0d sheet bytes and checked %0d spans over tracks 0, 99, 100, 127 and random",
             sb.n_bytes, sb.n_checked);
    $display("tracks, with random gaps on both sides and one long output hold-off.");
    if (sb.errors == 0 && sb.expected_spans.size() == 0) begin
      $display("cue_track_span_extractor verification clean");
    end else begin
      $display("cue_track_span_extractor verification failed");
    end
    $finish;
  end

endmodule
